// ===== design/circular_list_position_engine_unit_macros.svh =====
// assertion macros for the list engine
`ifndef CIRCULAR_LIST_POSITION_ENGINE_UNIT_MACROS_SVH
`define CIRCULAR_LIST_POSITION_ENGINE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CLPE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define CLPE_ASSERT_CLK(lbl, prop, msg) `CLPE_ASSERT(lbl, clk, arst_n, prop, msg)
`else
`define CLPE_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define CLPE_ASSERT_CLK(lbl, prop, msg)
`endif

`endif

// ===== design/clpe_pkg.sv =====
package clpe_pkg;

	localparam int OP_W   = 3;
	localparam int ST_W   = 3;
	localparam int DATA_W = 32;
	localparam int POS_W  = 16;
	localparam int CNT_W  = 7;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

	localparam logic [ST_W-1:0] ST_OK     = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 3'd1;
	localparam logic [ST_W-1:0] ST_BADPOS = 3'd2;
	localparam logic [ST_W-1:0] ST_RANGE  = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL   = 3'd4;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] removed_value;
		logic [CNT_W-1:0]         element_count;
	} res_t;

endpackage

// ===== design/clpe_if.sv =====
interface clpe_req_if;
	import clpe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;
	logic signed [POS_W-1:0]  position;

	modport source (output valid, output operation, output value, output position, input ready);
	modport sink (input valid, input operation, input value, input position, output ready);
endinterface

interface clpe_rsp_if;
	import clpe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] removed_value;
	logic [CNT_W-1:0]         element_count;

	modport source (output valid, output status, output removed_value, output element_count,
		input ready);
	modport sink (input valid, input status, input removed_value, input element_count,
		output ready);
endinterface

// ===== design/circular_list_position_engine_unit.sv =====
// channel | dir | payload                                 | transfer
// req     | in  | operation, value, position              | valid && ready
// rsp     | out | status, removed_value, element_count    | valid && ready
//
// one request at a time; rejects go straight from S_IDLE to S_DONE, end inserts and front deletes take no link walk
// mid-list positional operations and rear deletes of lists longer than one walk the link memory
// one link per cycle, a rate set by the single link read port
// arst_n clears the list to empty and the free pool to all slots; no memory sweep
// a finished result sits in the output register while the next request is taken
`include "circular_list_position_engine_unit_macros.svh"

module circular_list_position_engine_unit #(
	parameter int DEPTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	clpe_req_if.sink    req,
	clpe_rsp_if.source  rsp
);
	import clpe_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic          res_valid, res_ready;
	res_t          res;
	logic          lwe, vwe;
	logic [IW-1:0] lwaddr, lwdata, lraddr, lrdata, vwaddr, vraddr;
	logic [DATA_W-1:0] vwdata, vrdata;

	logic out_valid_q;
	res_t out_q;

	clpe_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.lwe       (lwe),
		.lwaddr    (lwaddr),
		.lwdata    (lwdata),
		.lraddr    (lraddr),
		.lrdata    (lrdata),
		.vwe       (vwe),
		.vwaddr    (vwaddr),
		.vwdata    (vwdata),
		.vraddr    (vraddr),
		.vrdata    (vrdata)
	);

	clpe_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.raddr (lraddr),
		.rdata (lrdata)
	);

	clpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (vwe),
		.waddr (vwaddr),
		.wdata (vwdata),
		.raddr (vraddr),
		.rdata (vrdata)
	);

	// output register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.removed_value = out_q.removed_value;
	assign rsp.element_count = out_q.element_count;

	`CLPE_ASSERT_CLK(a_busy_after_req, req.valid && req.ready |=> !req.ready, "request taken while busy")
	`CLPE_ASSERT_CLK(a_count_bound, rsp.valid |-> rsp.element_count <= CNT_W'(DEPTH), "count above depth")
	`CLPE_ASSERT_CLK(a_removed_zero, rsp.valid && rsp.status != ST_OK |-> rsp.removed_value == '0, "removed value on failure")
	`CLPE_ASSERT_CLK(a_full_count, rsp.valid && rsp.status == ST_FULL |-> rsp.element_count == CNT_W'(DEPTH), "full status below depth")
endmodule

// ===== design/clpe_ram.sv =====
module clpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/clpe_seq.sv =====
module clpe_seq #(
	parameter int DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	clpe_req_if.sink                     req,
	output logic                         res_valid,
	input  logic                         res_ready,
	output clpe_pkg::res_t               res,
	output logic                         lwe,
	output logic [$clog2(DEPTH)-1:0]     lwaddr,
	output logic [$clog2(DEPTH)-1:0]     lwdata,
	output logic [$clog2(DEPTH)-1:0]     lraddr,
	input  logic [$clog2(DEPTH)-1:0]     lrdata,
	output logic                         vwe,
	output logic [$clog2(DEPTH)-1:0]     vwaddr,
	output logic [clpe_pkg::DATA_W-1:0]  vwdata,
	output logic [$clog2(DEPTH)-1:0]     vraddr,
	input  logic [clpe_pkg::DATA_W-1:0]  vrdata
);
	import clpe_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ALLOC    = 4'd1;
	localparam logic [3:0] S_ALLOC_RD = 4'd2;
	localparam logic [3:0] S_INS_A    = 4'd3;
	localparam logic [3:0] S_INS_B    = 4'd4;
	localparam logic [3:0] S_WSTART   = 4'd5;
	localparam logic [3:0] S_WALK     = 4'd6;
	localparam logic [3:0] S_MID_A    = 4'd7;
	localparam logic [3:0] S_MID_B    = 4'd8;
	localparam logic [3:0] S_DEL_RD   = 4'd9;
	localparam logic [3:0] S_DF_RD    = 4'd10;
	localparam logic [3:0] S_DF_W     = 4'd11;
	localparam logic [3:0] S_PUSH     = 4'd12;
	localparam logic [3:0] S_DONE     = 4'd13;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_END    = 3'd1;
	localparam logic [2:0] ACT_MID    = 3'd2;
	localparam logic [2:0] ACT_DFRONT = 3'd3;
	localparam logic [2:0] ACT_DAFTER = 3'd4;

	logic [3:0]               st_q;
	logic [2:0]               act_q;
	logic                     front_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            rem_q;
	logic [IW-1:0]            head_q, tail_q, n_q, prev_q, cur_q, fhead_q;
	logic [CW-1:0]            cnt_q, fresh_q, fcnt_q;
	logic [ST_W-1:0]          status_q;
	logic signed [DATA_W-1:0] removed_q;

	logic [ST_W-1:0] dec_status;
	logic [2:0]      dec_act;
	logic            dec_front;
	logic [CW-1:0]   dec_k;
	logic            full, empty, pos_lt1, pos_is1, pos_gt_cnt;
	logic [14:0]     pos_m1;
	logic [CW-1:0]   pos_k, cnt_m1;

	// request decode
	always_comb begin
		full       = cnt_q == CW'(DEPTH);
		empty      = cnt_q == '0;
		pos_lt1    = req.position[POS_W-1] || (req.position == '0);
		pos_is1    = req.position == POS_W'(1);
		pos_gt_cnt = req.position[14:0] > 15'(cnt_q);
		pos_m1     = req.position[14:0] - 15'd1;
		pos_k      = pos_m1[CW-1:0];
		cnt_m1     = cnt_q - CW'(1);
		dec_status = ST_OK;
		dec_act    = ACT_NONE;
		dec_front  = 1'b1;
		dec_k      = '0;
		case (req.operation)
			OP_INS_FRONT, OP_INS_REAR: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_act   = ACT_END;
					dec_front = req.operation == OP_INS_FRONT;
				end
			end
			OP_INS_POS: begin
				if (pos_lt1) begin
					dec_status = ST_BADPOS;
				end else if (full) begin
					dec_status = ST_FULL;
				end else if (pos_is1) begin
					dec_act = ACT_END;
				end else if (empty) begin
					dec_status = ST_RANGE;
				end else if (pos_gt_cnt) begin
					dec_act   = ACT_END;
					dec_front = 1'b0;
				end else begin
					dec_act = ACT_MID;
					dec_k   = pos_k;
				end
			end
			OP_DEL_FRONT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_act = ACT_DFRONT;
				end
			end
			OP_DEL_REAR: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (cnt_q == CW'(1)) begin
					dec_act = ACT_DFRONT;
				end else begin
					dec_act = ACT_DAFTER;
					dec_k   = cnt_m1;
				end
			end
			OP_DEL_POS: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (pos_lt1) begin
					dec_status = ST_BADPOS;
				end else if (pos_gt_cnt) begin
					dec_status = ST_RANGE;
				end else if (pos_is1) begin
					dec_act = ACT_DFRONT;
				end else begin
					dec_act = ACT_DAFTER;
					dec_k   = pos_k;
				end
			end
			default: begin
				dec_act = ACT_NONE;
			end
		endcase
	end

	// memory port drive
	always_comb begin
		lwe    = 1'b0;
		lwaddr = cur_q;
		lwdata = fhead_q;
		lraddr = head_q;
		vwe    = 1'b0;
		vwaddr = n_q;
		vwdata = val_q;
		vraddr = head_q;
		case (st_q)
			S_ALLOC: begin
				lraddr = fhead_q;
			end
			S_INS_A: begin
				vwe    = 1'b1;
				lwe    = 1'b1;
				lwaddr = n_q;
				lwdata = empty ? n_q : head_q;
			end
			S_INS_B: begin
				lwe    = 1'b1;
				lwaddr = tail_q;
				lwdata = n_q;
			end
			S_WALK: begin
				lraddr = lrdata;
				vraddr = lrdata;
			end
			S_MID_A: begin
				vwe    = 1'b1;
				lwe    = 1'b1;
				lwaddr = n_q;
				lwdata = cur_q;
			end
			S_MID_B: begin
				lwe    = 1'b1;
				lwaddr = prev_q;
				lwdata = n_q;
			end
			S_DEL_RD: begin
				lwe    = 1'b1;
				lwaddr = prev_q;
				lwdata = lrdata;
			end
			S_DF_W: begin
				lwe    = 1'b1;
				lwaddr = tail_q;
				lwdata = lrdata;
			end
			S_PUSH: begin
				lwe    = 1'b1;
				lwaddr = cur_q;
				lwdata = fhead_q;
			end
			default: begin
				lwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			act_q     <= ACT_NONE;
			front_q   <= 1'b0;
			val_q     <= '0;
			rem_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			n_q       <= '0;
			prev_q    <= '0;
			cur_q     <= '0;
			fhead_q   <= '0;
			cnt_q     <= '0;
			fresh_q   <= '0;
			fcnt_q    <= '0;
			status_q  <= ST_OK;
			removed_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						status_q  <= dec_status;
						act_q     <= dec_act;
						front_q   <= dec_front;
						val_q     <= req.value;
						rem_q     <= dec_k;
						removed_q <= '0;
						case (dec_act)
							ACT_END, ACT_MID: st_q <= S_ALLOC;
							ACT_DFRONT:       st_q <= S_DF_RD;
							ACT_DAFTER:       st_q <= S_WSTART;
							default:          st_q <= S_DONE;
						endcase
					end
				end
				S_ALLOC: begin
					if (fcnt_q != '0) begin
						n_q  <= fhead_q;
						st_q <= S_ALLOC_RD;
					end else begin
						n_q     <= fresh_q[IW-1:0];
						fresh_q <= fresh_q + CW'(1);
						st_q    <= (act_q == ACT_END) ? S_INS_A : S_WSTART;
					end
				end
				S_ALLOC_RD: begin
					fhead_q <= lrdata;
					fcnt_q  <= fcnt_q - CW'(1);
					st_q    <= (act_q == ACT_END) ? S_INS_A : S_WSTART;
				end
				S_INS_A: begin
					if (empty) begin
						head_q <= n_q;
						tail_q <= n_q;
						cnt_q  <= cnt_q + CW'(1);
						st_q   <= S_DONE;
					end else begin
						st_q <= S_INS_B;
					end
				end
				S_INS_B: begin
					if (front_q) begin
						head_q <= n_q;
					end else begin
						tail_q <= n_q;
					end
					cnt_q <= cnt_q + CW'(1);
					st_q  <= S_DONE;
				end
				S_WSTART: begin
					cur_q <= head_q;
					st_q  <= S_WALK;
				end
				S_WALK: begin
					prev_q <= cur_q;
					cur_q  <= lrdata;
					rem_q  <= rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						st_q <= (act_q == ACT_MID) ? S_MID_A : S_DEL_RD;
					end
				end
				S_MID_A: begin
					st_q <= S_MID_B;
				end
				S_MID_B: begin
					cnt_q <= cnt_q + CW'(1);
					st_q  <= S_DONE;
				end
				S_DEL_RD: begin
					if (cur_q == tail_q) begin
						tail_q <= prev_q;
					end
					removed_q <= vrdata;
					st_q      <= S_PUSH;
				end
				S_DF_RD: begin
					cur_q <= head_q;
					st_q  <= S_DF_W;
				end
				S_DF_W: begin
					head_q    <= lrdata;
					removed_q <= vrdata;
					st_q      <= S_PUSH;
				end
				S_PUSH: begin
					fhead_q <= cur_q;
					fcnt_q  <= fcnt_q + CW'(1);
					cnt_q   <= cnt_m1;
					if (cnt_q == CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = st_q == S_IDLE;
	assign res_valid         = st_q == S_DONE;
	assign res.status        = status_q;
	assign res.removed_value = removed_q;
	assign res.element_count = CNT_W'(cnt_q);
endmodule
